// ===== rtl/ssw_pkg.sv =====
package ssw_pkg;

    // field widths
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int CFG_IDX_W = 2;

    // square root unit: radicand below 2^66, root of 33 bits
    localparam int SQ_W     = 33;
    localparam int SQ_IN_W  = 2 * SQ_W;
    localparam int SQ_REM_W = SQ_W + 3;

    // divider unit: 64-bit dividend, 33-bit divisor, quotient known below 2^31
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 33;
    localparam int QUO_W     = DIV_NUM_W - DIV_DEN_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STANDOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE    = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] STANDOFF_RST = 31'd0;
    localparam logic [CFG_W-1:0] SPEED_RST    = 31'd4096000;
    localparam logic [CFG_W-1:0] FORCE_RST    = 31'd2048000;

    // offset length over 25 as (m * ceil(2^38 / 25)) >> 38, exact for m below 2^33;
    // the reciprocal is split in two halves so each product stays narrow
    localparam int SPD_RCP_W = 34;
    localparam int SPD_SPLIT = 17;
    localparam int SPD_SHIFT = 38;
    localparam int SPD_PRD_W = SQ_W + SPD_SPLIT;
    localparam int SPD_SUM_W = SQ_W + SPD_RCP_W;
    localparam int SPD_LAT   = 2;
    localparam logic [SPD_RCP_W-1:0] SPD_RECIP = 34'd10995116278;
    localparam logic [SPD_SPLIT-1:0] SPD_RECIP_LO = SPD_RECIP[SPD_SPLIT-1:0];
    localparam logic [SPD_RCP_W-SPD_SPLIT-1:0] SPD_RECIP_HI = SPD_RECIP[SPD_RCP_W-1:SPD_SPLIT];

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // magnitude of a 33-bit two's complement value
    function automatic logic [DIFF_W-1:0] mag33(input logic [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : v;
    endfunction

    // clamp a 33-bit signed value into 32 bits
    function automatic logic [DATA_W-1:0] sat32(input logic [DIFF_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v[DIFF_W-1] != v[DIFF_W-2]) begin
            r = v[DIFF_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ssw_sqrt.sv =====
module ssw_sqrt (
    input  logic                        i_clk,
    input  logic [ssw_pkg::SQ_IN_W-1:0] i_rad,
    output logic [ssw_pkg::SQ_W-1:0]    o_root
);
    import ssw_pkg::*;

    logic [SQ_REM_W-1:0] r_rem  [SQ_W];
    logic [SQ_W-1:0]     r_root [SQ_W];
    logic [SQ_IN_W-1:0]  r_rad  [SQ_W];

    // one root bit per stage, digit by digit with remainder
    for (genvar k = 0; k < SQ_W; k++) begin : g_stage
        logic [SQ_REM_W-1:0] w_rem_in;
        logic [SQ_W-1:0]     w_root_in;
        logic [SQ_IN_W-1:0]  w_rad_in;
        logic [SQ_REM_W-1:0] w_cur;
        logic [SQ_REM_W-1:0] w_trial;
        logic                w_ge;
        logic [SQ_REM_W-1:0] n_rem;
        logic [SQ_W-1:0]     n_root;
        logic [SQ_IN_W-1:0]  n_rad;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
        end

        always_comb begin
            w_cur   = {w_rem_in[SQ_REM_W-3:0], w_rad_in[SQ_IN_W-1 -: 2]};
            w_trial = {1'b0, w_root_in, 2'b01};
            w_ge    = (w_cur >= w_trial);
            n_rem   = w_ge ? SQ_REM_W'(w_cur - w_trial) : w_cur;
            n_root  = {w_root_in[SQ_W-2:0], w_ge};
            n_rad   = {w_rad_in[SQ_IN_W-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_rad[k]  <= n_rad;
        end
    end

    assign o_root = r_root[SQ_W-1];

endmodule

// ===== rtl/ssw_div.sv =====
module ssw_div (
    input  logic                          i_clk,
    input  logic [ssw_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [ssw_pkg::DIV_DEN_W-1:0] i_den,
    output logic [ssw_pkg::QUO_W-1:0]     o_quo
);
    import ssw_pkg::*;

    logic [DIV_DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0]     r_low [QUO_W];
    logic [DIV_DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0]     r_quo [QUO_W];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DIV_DEN_W-1:0] w_rem_in;
        logic [QUO_W-1:0]     w_low_in;
        logic [DIV_DEN_W-1:0] w_den_in;
        logic [QUO_W-1:0]     w_quo_in;
        logic [DIV_DEN_W:0]   w_t;
        logic                 w_ge;
        logic [DIV_DEN_W-1:0] n_rem;
        logic [QUO_W-1:0]     n_low;
        logic [QUO_W-1:0]     n_quo;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num[DIV_NUM_W-1 -: DIV_DEN_W];
            assign w_low_in = i_num[QUO_W-1:0];
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_low_in = r_low[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        always_comb begin
            w_t   = {w_rem_in, w_low_in[QUO_W-1]};
            w_ge  = (w_t >= {1'b0, w_den_in});
            n_rem = w_ge ? DIV_DEN_W'(w_t - {1'b0, w_den_in}) : w_t[DIV_DEN_W-1:0];
            n_low = {w_low_in[QUO_W-2:0], 1'b0};
            n_quo = {w_quo_in[QUO_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_low[k] <= n_low;
            r_den[k] <= w_den_in;
            r_quo[k] <= n_quo;
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ===== rtl/seek_steering_with_standoff.sv =====
// seek steering with standoff, 3D, signed Q20.12
// request channel: drive the nine vector fields and pulse i_start; a request is
// taken at every rising edge with i_start high, o_busy is always low, so a new
// request may come in every cycle
// result channel: o_strobe is high for one cycle with o_steer_x/y/z valid; the
// receiver cannot stall and results leave in request order
// pipeline depth: o_strobe follows the edge that took the request; the depth is
// set by the two 33-stage square root pipelines, the two rounds of
// 31-stage dividers (per-axis desired speed and clamp scaling) and the 2-stage
// reciprocal multiply for the speed over 25
// throughput: one request per cycle, sustained
// config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high, index 0 standoff, 1 speed limit, 2 force limit,
// other indexes ignored; write only while no request is in flight
// reset (i_rst_n low, synchronous): the pipeline empties, no strobe follows,
// and the limits return to their defaults
module seek_steering_with_standoff (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [ssw_pkg::DATA_W-1:0]   i_target_x,
    input  logic signed [ssw_pkg::DATA_W-1:0]   i_target_y,
    input  logic signed [ssw_pkg::DATA_W-1:0]   i_target_z,
    input  logic signed [ssw_pkg::DATA_W-1:0]   i_pos_x,
    input  logic signed [ssw_pkg::DATA_W-1:0]   i_pos_y,
    input  logic signed [ssw_pkg::DATA_W-1:0]   i_pos_z,
    input  logic signed [ssw_pkg::DATA_W-1:0]   i_vel_x,
    input  logic signed [ssw_pkg::DATA_W-1:0]   i_vel_y,
    input  logic signed [ssw_pkg::DATA_W-1:0]   i_vel_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ssw_pkg::DATA_W-1:0]          i_cfg_data,
    output logic                                o_strobe,
    output logic signed [ssw_pkg::DATA_W-1:0]   o_steer_x,
    output logic signed [ssw_pkg::DATA_W-1:0]   o_steer_y,
    output logic signed [ssw_pkg::DATA_W-1:0]   o_steer_z
);
    import ssw_pkg::*;

    // stage positions along the valid chain
    localparam int ST_D = 3;
    localparam int ST_E = ST_D + SQ_W + 1;
    localparam int ST_F = ST_E + SPD_LAT + 1;
    localparam int ST_G = ST_F + 1;
    localparam int ST_H = ST_G + QUO_W + 1;
    localparam int ST_I = ST_H + 1;
    localparam int ST_J = ST_I + 1;
    localparam int ST_L = ST_J + SQ_W + 1;
    localparam int ST_M = ST_L + QUO_W + 1;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] d;
        logic [2:0][DATA_W-1:0] vel;
    } t_side_d;

    typedef struct packed {
        logic [SQ_W-1:0]        len;
        logic                   zero;
        logic [2:0]             neg;
        logic [2:0][DIFF_W-1:0] dmag;
        logic [2:0][DATA_W-1:0] vel;
    } t_side_e;

    typedef struct packed {
        logic                   zero;
        logic [2:0]             neg;
        logic [2:0][DATA_W-1:0] vel;
    } t_side_g;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] steer;
        logic                   over;
    } t_side_s;

    logic             accept;
    logic [ST_M:0]    r_vld;

    logic [CFG_W-1:0]   r_standoff;
    logic [CFG_W-1:0]   r_speed_lim;
    logic [CFG_W-1:0]   r_force_lim;
    logic [2*CFG_W-1:0] r_fl_sq;

    logic [2:0][DATA_W-1:0]   r_a_tgt;
    logic [2:0][DATA_W-1:0]   r_a_pos;
    logic [2:0][DATA_W-1:0]   r_a_vel;
    logic [2:0][DIFF_W-1:0]   r_b_d;
    logic [2:0][DATA_W-1:0]   r_b_vel;
    logic [2:0][SQ_IN_W-1:0]  r_c_sq;
    t_side_d                  r_c_side;
    logic [SQ_IN_W-1:0]       r_d_sum;
    t_side_d                  r_d_side;
    t_side_d                  r_dly_d [SQ_W];
    logic [SQ_W-1:0]          w_len;

    logic                     w_inside;
    logic [SQ_W-1:0]          w_sd;
    logic [SQ_W-1:0]          r_e_m;
    t_side_e                  r_e_side;
    t_side_e                  r_dly_e [SPD_LAT];
    logic [SPD_PRD_W-1:0]     r_s1_lo;
    logic [SPD_PRD_W-1:0]     r_s1_hi;
    logic [SPD_SUM_W-1:0]     w_s2_sum;
    logic [QUO_W-1:0]         r_s2_spd;

    logic [CFG_W-1:0]         r_f_speed;
    t_side_e                  r_f_side;
    logic [2:0][DIV_NUM_W-1:0] r_g_prod;
    logic [SQ_W-1:0]          r_g_len;
    t_side_g                  r_g_side;
    t_side_g                  r_dly_g [QUO_W];
    logic [QUO_W-1:0]         w_q1 [3];

    logic signed [DIFF_W-1:0] w_des [3];
    logic [2:0][DIFF_W-1:0]   r_h_steer;
    logic [2:0][SQ_IN_W-1:0]  r_i_sq;
    logic [2:0][DIFF_W-1:0]   r_i_steer;
    logic [SQ_IN_W-1:0]       r_j_sum;
    logic [2:0][DIFF_W-1:0]   r_j_steer;
    t_side_s                  r_dly_j [SQ_W];
    logic [SQ_W-1:0]          w_slen;

    logic [2:0][DIV_NUM_W-1:0] r_l_prod;
    logic [SQ_W-1:0]          r_l_slen;
    t_side_s                  r_l_side;
    t_side_s                  r_dly_l [QUO_W];
    logic [QUO_W-1:0]         w_q2 [3];

    logic [2:0][DATA_W-1:0]   r_steer;

    // handshakes
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_standoff  <= STANDOFF_RST;
            r_speed_lim <= SPEED_RST;
            r_force_lim <= FORCE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STANDOFF: r_standoff  <= i_cfg_data[CFG_W-1:0];
                CFG_SPEED:    r_speed_lim <= i_cfg_data[CFG_W-1:0];
                CFG_FORCE:    r_force_lim <= i_cfg_data[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // squared force limit for the clamp test
    always_ff @(posedge i_clk) begin
        r_fl_sq <= r_force_lim * r_force_lim;
    end

    // valid bits, one per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ST_M-1:0], accept};
        end
    end

    // capture, offset, squares, sum of squares
    always_ff @(posedge i_clk) begin
        r_a_tgt <= {i_target_z, i_target_y, i_target_x};
        r_a_pos <= {i_pos_z, i_pos_y, i_pos_x};
        r_a_vel <= {i_vel_z, i_vel_y, i_vel_x};
        for (int i = 0; i < 3; i++) begin
            r_b_d[i] <= $signed({r_a_tgt[i][DATA_W-1], r_a_tgt[i]})
                      - $signed({r_a_pos[i][DATA_W-1], r_a_pos[i]});
            r_c_sq[i] <= mag33(r_b_d[i]) * mag33(r_b_d[i]);
        end
        r_b_vel        <= r_a_vel;
        r_c_side.d     <= r_b_d;
        r_c_side.vel   <= r_b_vel;
        r_d_sum        <= r_c_sq[0] + r_c_sq[1] + r_c_sq[2];
        r_d_side       <= r_c_side;
    end

    // offset length
    ssw_sqrt u_sqrt_len (
        .i_clk  (i_clk),
        .i_rad  (r_d_sum),
        .o_root (w_len)
    );

    always_ff @(posedge i_clk) begin
        r_dly_d[0] <= r_d_side;
        for (int k = 1; k < SQ_W; k++) begin
            r_dly_d[k] <= r_dly_d[k-1];
        end
    end

    // distance to the standoff, on either side, and per-axis direction signs
    assign w_sd     = SQ_W'(r_standoff);
    assign w_inside = (w_len < w_sd);

    always_ff @(posedge i_clk) begin
        r_e_m         <= w_inside ? SQ_W'(w_sd - w_len) : SQ_W'(w_len - w_sd);
        r_e_side.len  <= w_len;
        r_e_side.zero <= (w_len == '0) || (w_len == w_sd);
        for (int i = 0; i < 3; i++) begin
            r_e_side.neg[i]  <= r_dly_d[SQ_W-1].d[i][DIFF_W-1] ^ w_inside;
            r_e_side.dmag[i] <= mag33(r_dly_d[SQ_W-1].d[i]);
        end
        r_e_side.vel  <= r_dly_d[SQ_W-1].vel;
    end

    // speed from distance: reciprocal multiply, partial products then sum and shift
    assign w_s2_sum = {r_s1_hi, {SPD_SPLIT{1'b0}}} + SPD_SUM_W'(r_s1_lo);

    always_ff @(posedge i_clk) begin
        r_s1_lo  <= r_e_m * SPD_RECIP_LO;
        r_s1_hi  <= r_e_m * SPD_RECIP_HI;
        r_s2_spd <= QUO_W'(w_s2_sum[SPD_SUM_W-1:SPD_SHIFT]);
    end

    always_ff @(posedge i_clk) begin
        r_dly_e[0] <= r_e_side;
        for (int k = 1; k < SPD_LAT; k++) begin
            r_dly_e[k] <= r_dly_e[k-1];
        end
    end

    // speed cap, then axis products
    always_ff @(posedge i_clk) begin
        r_f_speed <= (r_s2_spd > r_speed_lim) ? r_speed_lim : r_s2_spd;
        r_f_side  <= r_dly_e[SPD_LAT-1];
        for (int i = 0; i < 3; i++) begin
            r_g_prod[i] <= r_f_side.dmag[i] * r_f_speed;
        end
        r_g_len       <= r_f_side.len;
        r_g_side.zero <= r_f_side.zero;
        r_g_side.neg  <= r_f_side.neg;
        r_g_side.vel  <= r_f_side.vel;
    end

    // desired velocity magnitude per axis
    for (genvar i = 0; i < 3; i++) begin : g_div_des
        ssw_div u_div (
            .i_clk (i_clk),
            .i_num (r_g_prod[i]),
            .i_den (r_g_len),
            .o_quo (w_q1[i])
        );
    end

    always_ff @(posedge i_clk) begin
        r_dly_g[0] <= r_g_side;
        for (int k = 1; k < QUO_W; k++) begin
            r_dly_g[k] <= r_dly_g[k-1];
        end
    end

    // signed desired velocity
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dly_g[QUO_W-1].zero) begin
                w_des[i] = '0;
            end else if (r_dly_g[QUO_W-1].neg[i]) begin
                w_des[i] = -$signed(DIFF_W'(w_q1[i]));
            end else begin
                w_des[i] = $signed(DIFF_W'(w_q1[i]));
            end
        end
    end

    // steering vector, its squares and squared length
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_h_steer[i] <= w_des[i] - $signed({r_dly_g[QUO_W-1].vel[i][DATA_W-1],
                                                r_dly_g[QUO_W-1].vel[i]});
            r_i_sq[i]    <= mag33(r_h_steer[i]) * mag33(r_h_steer[i]);
        end
        r_i_steer <= r_h_steer;
        r_j_sum   <= r_i_sq[0] + r_i_sq[1] + r_i_sq[2];
        r_j_steer <= r_i_steer;
    end

    // steering length
    ssw_sqrt u_sqrt_steer (
        .i_clk  (i_clk),
        .i_rad  (r_j_sum),
        .o_root (w_slen)
    );

    always_ff @(posedge i_clk) begin
        r_dly_j[0].steer <= r_j_steer;
        r_dly_j[0].over  <= (r_j_sum > SQ_IN_W'(r_fl_sq));
        for (int k = 1; k < SQ_W; k++) begin
            r_dly_j[k] <= r_dly_j[k-1];
        end
    end

    // clamp products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_l_prod[i] <= mag33(r_dly_j[SQ_W-1].steer[i]) * r_force_lim;
        end
        r_l_slen <= w_slen;
        r_l_side <= r_dly_j[SQ_W-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_div_clamp
        ssw_div u_div (
            .i_clk (i_clk),
            .i_num (r_l_prod[i]),
            .i_den (r_l_slen),
            .o_quo (w_q2[i])
        );
    end

    always_ff @(posedge i_clk) begin
        r_dly_l[0] <= r_l_side;
        for (int k = 1; k < QUO_W; k++) begin
            r_dly_l[k] <= r_dly_l[k-1];
        end
    end

    // output register: scaled when over the limit, else saturated
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_dly_l[QUO_W-1].over) begin
                r_steer[i] <= r_dly_l[QUO_W-1].steer[i][DIFF_W-1]
                            ? DATA_W'(-{1'b0, w_q2[i]}) : DATA_W'(w_q2[i]);
            end else begin
                r_steer[i] <= sat32(r_dly_l[QUO_W-1].steer[i]);
            end
        end
    end

    assign o_strobe  = r_vld[ST_M];
    assign o_steer_x = r_steer[0];
    assign o_steer_y = r_steer[1];
    assign o_steer_z = r_steer[2];

endmodule

// ===== tb/seek_steering_with_standoff_test.sv =====
module seek_steering_with_standoff_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssw_pkg::*;

    localparam int LATENCY = 141;

    // an index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] tx;
        logic signed [DATA_W-1:0] ty;
        logic signed [DATA_W-1:0] tz;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] vz;
    } t_seek_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } t_steer;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic                     o_busy;
    logic signed [DATA_W-1:0] i_target_x = '0;
    logic signed [DATA_W-1:0] i_target_y = '0;
    logic signed [DATA_W-1:0] i_target_z = '0;
    logic signed [DATA_W-1:0] i_pos_x = '0;
    logic signed [DATA_W-1:0] i_pos_y = '0;
    logic signed [DATA_W-1:0] i_pos_z = '0;
    logic signed [DATA_W-1:0] i_vel_x = '0;
    logic signed [DATA_W-1:0] i_vel_y = '0;
    logic signed [DATA_W-1:0] i_vel_z = '0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_steer_x;
    logic signed [DATA_W-1:0] o_steer_y;
    logic signed [DATA_W-1:0] o_steer_z;

    // shadow copy of the limit registers
    logic [CFG_W-1:0] standoff_reg = STANDOFF_RST;
    logic [CFG_W-1:0] speed_reg    = SPEED_RST;
    logic [CFG_W-1:0] force_reg    = FORCE_RST;

    t_steer steer_queue[$];
    int     error_count = 0;
    bit     no_gaps = 0;

    seek_steering_with_standoff i_dut (.*);

    // clock
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [69:0] length_sq(input longint a, input longint b, input longint c);
        return 70'(abs64(a)) * 70'(abs64(a)) + 70'(abs64(b)) * 70'(abs64(b))
             + 70'(abs64(c)) * 70'(abs64(c));
    endfunction

    // floor square root
    function automatic logic [34:0] floor_root(input logic [69:0] s);
        logic [34:0] r;
        logic [34:0] t;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            t = r | (35'd1 << b);
            if (70'(t) * 70'(t) <= s) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return SAT_MAX;
        end else if (v < -64'sd2147483648) begin
            return SAT_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // expected steering vector for one request
    function automatic t_steer predict_steer(input t_seek_req r);
        longint       d[3];
        longint       st[3];
        longint       vel[3];
        longint       des;
        logic [34:0]  len;
        logic [34:0]  m;
        logic [34:0]  slen;
        logic [63:0]  spd;
        logic [127:0] q;
        bit           in_standoff;
        bit           neg;
        t_steer       o;
        d[0] = longint'(r.tx) - longint'(r.px);
        d[1] = longint'(r.ty) - longint'(r.py);
        d[2] = longint'(r.tz) - longint'(r.pz);
        vel[0] = longint'(r.vx);
        vel[1] = longint'(r.vy);
        vel[2] = longint'(r.vz);
        len = floor_root(length_sq(d[0], d[1], d[2]));
        in_standoff = len < 35'(standoff_reg);
        m = in_standoff ? 35'(standoff_reg) - len : len - 35'(standoff_reg);
        spd = 64'(m) / 64'd25;
        if (spd > 64'(speed_reg)) begin
            spd = 64'(speed_reg);
        end
        for (int i = 0; i < 3; i++) begin
            if (len == 0 || m == 0) begin
                des = 0;
            end else begin
                q = 128'(abs64(d[i])) * 128'(spd) / 128'(len);
                neg = (d[i] < 0) != in_standoff;
                des = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
            end
            st[i] = des - vel[i];
        end
        // clamp to the force limit
        if (length_sq(st[0], st[1], st[2]) > 70'(force_reg) * 70'(force_reg)) begin
            slen = floor_root(length_sq(st[0], st[1], st[2]));
            for (int i = 0; i < 3; i++) begin
                q = (slen != 0) ? 128'(abs64(st[i])) * 128'(force_reg) / 128'(slen) : '0;
                st[i] = st[i] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
            end
        end
        o.x = clamp32(st[0]);
        o.y = clamp32(st[1]);
        o.z = clamp32(st[2]);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_steer want;
        if (i_rst_n && o_strobe) begin
            if (steer_queue.size() == 0) begin
                report_mismatch("unexpected result", o_steer_x, '0);
            end else begin
                want = steer_queue.pop_front();
                if (o_steer_x !== want.x) report_mismatch("steer_x", o_steer_x, want.x);
                if (o_steer_y !== want.y) report_mismatch("steer_y", o_steer_y, want.y);
                if (o_steer_z !== want.z) report_mismatch("steer_z", o_steer_z, want.z);
            end
        end
    end

    // send one request; start stays high when the next one follows with no gap
    task automatic send_request(input t_seek_req r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(3);
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start    <= 1'b1;
        i_target_x <= r.tx;
        i_target_y <= r.ty;
        i_target_z <= r.tz;
        i_pos_x    <= r.px;
        i_pos_y    <= r.py;
        i_pos_z    <= r.pz;
        i_vel_x    <= r.vx;
        i_vel_y    <= r.vy;
        i_vel_z    <= r.vz;
        do @(posedge i_clk); while (o_busy);
        steer_queue.push_back(predict_steer(r));
    endtask

    // drain the pipeline before touching the limits
    task automatic wait_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (steer_queue.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_STANDOFF: standoff_reg = val[CFG_W-1:0];
            CFG_SPEED:    speed_reg    = val[CFG_W-1:0];
            CFG_FORCE:    force_reg    = val[CFG_W-1:0];
            default:      ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_seek_req make_req(input longint dx, input longint dy,
                                           input longint dz, input longint vx,
                                           input longint vy, input longint vz);
        t_seek_req r;
        r = '0;
        r.tx = DATA_W'(dx); r.ty = DATA_W'(dy); r.tz = DATA_W'(dz);
        r.vx = DATA_W'(vx); r.vy = DATA_W'(vy); r.vz = DATA_W'(vz);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_field();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return DATA_W'(int'($urandom_range(2097152)) - 1048576);
            2:       return DATA_W'(int'($urandom_range(1 << 28)) - (1 << 27));
            default: return DATA_W'(int'($urandom_range(65536)) - 32768);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_limit();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $urandom_range(1 << 24);
            2:       return $urandom_range(1 << 20);
            default: return $urandom_range(8192);
        endcase
    endfunction

    // default limits: zero offset, axes, field extremes
    task automatic test_default_limits();
        send_request(make_req(0, 0, 0, 0, 0, 0));
        send_request(make_req(0, 0, 0, 4096, -4096, 8192));
        send_request(make_req(409600, 0, 0, 0, 0, 0));
        send_request(make_req(0, -409600, 0, 0, 0, 0));
        send_request(make_req(0, 0, 123456789, 100, 200, 300));
        send_request({9{SAT_MAX}});
        send_request({9{SAT_MIN}});
        send_request({SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN,
                      SAT_MIN, SAT_MAX, SAT_MIN});
        send_request({SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX,
                      SAT_MAX, SAT_MIN, SAT_MAX});
    endtask

    // standoff reached exactly, inside, outside, target at agent
    task automatic test_standoff();
        write_limit(CFG_STANDOFF, 32'd40960);
        send_request(make_req(40960, 0, 0, 0, 0, 0));
        send_request(make_req(0, 0, -40960, 7, 0, 0));
        send_request(make_req(1000, -2000, 300, 0, 0, 0));
        send_request(make_req(0, 0, 0, 0, 0, 0));
        send_request(make_req(4096000, 4096000, -4096000, 0, 4096, 0));
    endtask

    // zero force limit, extreme limits, ignored index
    task automatic test_extreme_limits();
        write_limit(CFG_FORCE, 32'd0);
        send_request(make_req(409600, 0, 0, 4096, 4096, 4096));
        send_request(make_req(0, 0, 0, 0, 0, 0));
        write_limit(CFG_STANDOFF, 32'hffff_ffff);
        write_limit(CFG_SPEED, 32'hffff_ffff);
        write_limit(CFG_FORCE, 32'hffff_ffff);
        write_limit(CFG_UNUSED, 32'd0);
        send_request(make_req(0, 0, 0, 0, 0, 0));
        send_request({9{SAT_MAX}});
        send_request({SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN,
                      SAT_MIN, SAT_MIN, SAT_MIN});
        write_limit(CFG_STANDOFF, 32'd0);
        write_limit(CFG_SPEED, 32'd0);
        send_request(make_req(409600, 409600, 0, SAT_MIN, SAT_MAX, 0));
        send_request({SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX,
                      SAT_MIN, SAT_MIN, SAT_MIN});
    endtask

    // random requests under a series of limit settings
    task automatic test_random();
        t_seek_req r;
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(CFG_STANDOFF, ph == 0 ? 32'd0 : rand_limit());
            write_limit(CFG_SPEED, ph == 0 ? 32'(SPEED_RST) : rand_limit());
            write_limit(CFG_FORCE, ph == 0 ? 32'(FORCE_RST) : rand_limit());
            for (int n = 0; n < 250; n++) begin
                no_gaps = (n % 50) < 15;
                r = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
                     rand_field(), rand_field(), rand_field(), rand_field()};
                // sometimes put the target on the agent
                if ($urandom_range(15) == 0) begin
                    r.tx = r.px; r.ty = r.py; r.tz = r.pz;
                end
                send_request(r);
            end
            no_gaps = 0;
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_limits();
        test_standoff();
        test_extreme_limits();
        test_random();
        wait_idle();
        repeat (LATENCY + 20) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
